### sv/tra_pkg.sv
// Shared types, constants and arithmetic helpers of the tangent approximation block.
// Used by every module of the block; depends on nothing else.
package tra_pkg;

   localparam int AngleW = 32;
   localparam int TanW = 32;
   localparam int XW = 31;
   localparam int AccW = 36;
   localparam int DividendW = 52;
   localparam int QuotW = 32;
   localparam int DivSteps = 4;
   localparam int DivStages = QuotW / DivSteps;
   localparam int QueueDepthDefault = 4;

   localparam logic [31:0] KHi = 32'h145F306D;
   localparam logic [31:0] KLo = 32'hC9C882A5;
   localparam logic [XW-1:0] One30 = 31'h40000000;
   localparam logic [TanW-1:0] SatMag = 32'h7FFFFFFF;

   typedef enum logic [1:0] {
      OCT_ZERO  = 2'd0,
      OCT_ONE   = 2'd1,
      OCT_TWO   = 2'd2,
      OCT_THREE = 2'd3
   } octant_type;

   typedef struct packed {
      logic [XW-1:0] x;
      logic          inv;
      logic          neg;
   } item_type;

   function automatic logic signed [AccW-1:0] coef_p(input logic [2:0] k);
      case (k)
         3'd0: coef_p = -36'sd5712939549;
         3'd1: coef_p = 36'sd494685598;
         3'd2: coef_p = -36'sd9429037;
         3'd3: coef_p = 36'sd52827;
         3'd4: coef_p = -36'sd70;
         default: coef_p = '0;
      endcase
   endfunction

   function automatic logic signed [AccW-1:0] coef_q(input logic [2:0] k);
      case (k)
         3'd0: coef_q = -36'sd7273940551;
         3'd1: coef_q = 36'sd2125497342;
         3'd2: coef_q = -36'sd80007912;
         3'd3: coef_q = 36'sd823286;
         3'd4: coef_q = -36'sd2397;
         3'd5: coef_q = 36'sd1;
         default: coef_q = '0;
      endcase
   endfunction

   // Product scaled down by 2^30, truncated toward zero.
   function automatic logic signed [AccW-1:0] mul_q30(input logic signed [AccW-1:0] a,
                                                      input logic [XW-1:0] b);
      logic [AccW-1:0]    mag;
      logic [AccW+XW-1:0] prod;
      logic [AccW-1:0]    sh;
      mag = a[AccW-1] ? (~a + 36'd1) : a;
      prod = (AccW+XW)'(mag) * (AccW+XW)'(b);
      sh = prod[AccW+29:30];
      mul_q30 = a[AccW-1] ? $signed(~sh + 36'd1) : $signed(sh);
   endfunction

endpackage

### sv/tangent_rational_approx.sv
// Top level of the tangent approximation block: front part, queue and back part.
// Depends on tra_pkg, tra_front, tra_fifo and tra_back.
//
// Usage: each request on the req_ channel carries one angle in radians, signed Q8.24.
// The rsp_ channel returns one response per request, in order: the tangent as
// signed Q16.16 and a range flag that is set when the result was saturated to
// plus or minus 0x7FFFFFFF (near a pole or outside the Q16.16 range).
// Both channels complete a transfer when tvalid and tready are high at a clock edge.
// Throughput is one request per cycle while rsp_tready is high; fully pipelined.
// A request passes through three front stages, one queue slot, and sixteen back
// stages (Horner steps, an eight-stage divider producing four quotient bits per
// stage, and the output register).
// When the receiver holds rsp_tready low the back pipeline freezes; the front part
// keeps filling the queue and req_tready falls only once the queue is full.
// Synchronous reset empties all pipeline stages and the queue; no request is lost
// or repeated across a stall.
module tangent_rational_approx #(
   parameter int QueueDepth = tra_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] tangent
   output logic        rsp_tuser    // [0] range_error
);

   logic              f_valid, f_ready, b_valid, b_ready;
   tra_pkg::item_type f_item, b_item;

   tra_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_angle  (req_tdata),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   tra_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_item   (b_item)
   );

   tra_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (b_valid),
      .in_ready    (b_ready),
      .in_item     (b_item),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_tangent (rsp_tdata),
      .out_error   (rsp_tuser)
   );

endmodule

### sv/tra_front.sv
// Front part: takes the sign off the angle, scales by 4/pi and classifies the octant.
// Depends on tra_pkg.
module tra_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [tra_pkg::AngleW-1:0] in_angle,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tra_pkg::item_type      out_item
);

   logic        ce;
   logic        v1_ff, v2_ff, v3_ff;
   logic [31:0] m1_ff;
   logic        neg1_ff, neg2_ff;
   logic [63:0] lo2_ff, hi2_ff;
   tra_pkg::item_type item3_ff, item3_in;
   logic [63:0] t;
   tra_pkg::octant_type oct;
   logic [29:0] xr;

   assign ce = out_ready || !v3_ff;
   assign in_ready = ce;
   assign out_valid = v3_ff;
   assign out_item = item3_ff;

   assign t = hi2_ff + {32'd0, lo2_ff[63:32]};
   assign oct = tra_pkg::octant_type'(t[53:52]);
   assign xr = t[51:22];

   always_comb begin
      item3_in.x = {1'b0, xr};
      item3_in.inv = 1'b0;
      item3_in.neg = neg2_ff;
      case (oct)
         tra_pkg::OCT_ONE: begin
            item3_in.x = tra_pkg::One30 - {1'b0, xr};
            item3_in.inv = 1'b1;
         end
         tra_pkg::OCT_TWO: begin
            item3_in.neg = !neg2_ff;
            item3_in.inv = 1'b1;
         end
         tra_pkg::OCT_THREE: begin
            item3_in.x = tra_pkg::One30 - {1'b0, xr};
            item3_in.neg = !neg2_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (ce) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (ce) begin
         neg1_ff <= in_angle[31];
         m1_ff <= in_angle[31] ? (~in_angle + 32'd1) : in_angle;
         neg2_ff <= neg1_ff;
         lo2_ff <= 64'(m1_ff) * 64'(tra_pkg::KLo);
         hi2_ff <= 64'(m1_ff) * 64'(tra_pkg::KHi);
         item3_ff <= item3_in;
      end
   end

endmodule

### sv/tra_fifo.sv
// Short queue that decouples the front part from the back part.
// Depends on tra_pkg for the item type.
module tra_fifo #(
   parameter int Depth = tra_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tra_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tra_pkg::item_type pop_item
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   tra_pkg::item_type mem [Depth];
   logic [PtrW-1:0] wr_ff, rd_ff;
   logic [CntW-1:0] cnt_ff;
   logic push, pop;

   assign push_ready = cnt_ff != CntW'(Depth);
   assign pop_valid = cnt_ff != '0;
   assign pop_item = mem[rd_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + PtrW'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + CntW'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - CntW'(1);
         end
      end
      if (push) begin
         mem[wr_ff] <= push_item;
      end
   end

endmodule

### sv/tra_back.sv
// Back part: Horner evaluation of both polynomials, pipelined division and saturation.
// Depends on tra_pkg.
module tra_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  tra_pkg::item_type        in_item,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [tra_pkg::TanW-1:0] out_tangent,
   output logic                     out_error
);

   localparam int AW = tra_pkg::AccW;
   localparam int XW = tra_pkg::XW;
   localparam int DW = tra_pkg::DividendW;
   localparam int QW = tra_pkg::QuotW;
   localparam int NS = tra_pkg::DivStages;
   localparam int CW = AW + QW;

   logic ce;

   logic                 hv_ff  [6];
   logic [XW-1:0]        hx_ff  [6];
   logic [XW-1:0]        hsq_ff [6];
   logic                 hinv_ff[6];
   logic                 hneg_ff[6];
   logic signed [AW-1:0] hp_ff  [6];
   logic signed [AW-1:0] hq_ff  [6];

   logic          dv_ff  [NS+1];
   logic [DW-1:0] drem_ff[NS+1];
   logic [AW-1:0] ddvs_ff[NS+1];
   logic [QW-1:0] dq_ff  [NS+1];
   logic          dsat_ff[NS+1];
   logic          dneg_ff[NS+1];

   logic                 ov_ff, oerr_ff;
   logic [QW-1:0]        otan_ff;
   logic [2*XW-1:0]      sq_prod;
   logic [AW-1:0]        an, ad;
   logic [DW-1:0]        dividend_in;
   logic [AW-1:0]        divisor_in;
   logic                 sat_in;
   logic [QW-1:0]        mag_in;
   logic                 err_in;

   assign ce = out_ready || !ov_ff;
   assign in_ready = ce;
   assign out_valid = ov_ff;
   assign out_tangent = otan_ff;
   assign out_error = oerr_ff;

   assign sq_prod = (2*XW)'(in_item.x) * (2*XW)'(in_item.x);

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff[0] <= 1'b0;
      end else if (ce) begin
         hv_ff[0] <= in_valid;
      end
      if (ce) begin
         hx_ff[0] <= in_item.x;
         hsq_ff[0] <= sq_prod[XW+29:30];
         hinv_ff[0] <= in_item.inv;
         hneg_ff[0] <= in_item.neg;
         hp_ff[0] <= tra_pkg::coef_p(3'd4);
         hq_ff[0] <= tra_pkg::coef_q(3'd5);
      end
   end

   for (genvar j = 1; j < 6; j++) begin : g_horner
      logic signed [AW-1:0] p_in, q_in;
      always_comb begin
         q_in = tra_pkg::mul_q30(hq_ff[j-1], hsq_ff[j-1]) + tra_pkg::coef_q(3'(5 - j));
         if (j < 5) begin
            p_in = tra_pkg::mul_q30(hp_ff[j-1], hsq_ff[j-1]) + tra_pkg::coef_p(3'(4 - j));
         end else begin
            p_in = tra_pkg::mul_q30(hp_ff[j-1], hx_ff[j-1]);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            hv_ff[j] <= 1'b0;
         end else if (ce) begin
            hv_ff[j] <= hv_ff[j-1];
         end
         if (ce) begin
            hx_ff[j] <= hx_ff[j-1];
            hsq_ff[j] <= hsq_ff[j-1];
            hinv_ff[j] <= hinv_ff[j-1];
            hneg_ff[j] <= hneg_ff[j-1];
            hp_ff[j] <= p_in;
            hq_ff[j] <= q_in;
         end
      end
   end

   always_comb begin
      an = hp_ff[5][AW-1] ? (~hp_ff[5] + AW'(1)) : hp_ff[5];
      ad = hq_ff[5][AW-1] ? (~hq_ff[5] + AW'(1)) : hq_ff[5];
      dividend_in = hinv_ff[5] ? {ad[DW-17:0], 16'd0} : {an[DW-17:0], 16'd0};
      divisor_in = hinv_ff[5] ? an : ad;
      sat_in = {(CW - DW)'(0), dividend_in} >= {divisor_in, QW'(0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (ce) begin
         dv_ff[0] <= hv_ff[5];
      end
      if (ce) begin
         drem_ff[0] <= dividend_in;
         ddvs_ff[0] <= divisor_in;
         dq_ff[0] <= '0;
         dsat_ff[0] <= sat_in;
         dneg_ff[0] <= hneg_ff[5];
      end
   end

   for (genvar k = 1; k <= NS; k++) begin : g_div
      logic [DW-1:0] rem_in;
      logic [QW-1:0] q_in;
      logic [CW-1:0] trial;
      always_comb begin
         rem_in = drem_ff[k-1];
         q_in = dq_ff[k-1];
         for (int n = 0; n < tra_pkg::DivSteps; n++) begin
            trial = {(CW - AW)'(0), ddvs_ff[k-1]} << (QW - 1 - (k - 1) * tra_pkg::DivSteps - n);
            if ({(CW - DW)'(0), rem_in} >= trial) begin
               rem_in = rem_in - trial[DW-1:0];
               q_in[QW - 1 - (k - 1) * tra_pkg::DivSteps - n] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (ce) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         if (ce) begin
            drem_ff[k] <= rem_in;
            ddvs_ff[k] <= ddvs_ff[k-1];
            dq_ff[k] <= q_in;
            dsat_ff[k] <= dsat_ff[k-1];
            dneg_ff[k] <= dneg_ff[k-1];
         end
      end
   end

   always_comb begin
      err_in = dsat_ff[NS] || dq_ff[NS][QW-1];
      mag_in = err_in ? tra_pkg::SatMag : dq_ff[NS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (ce) begin
         ov_ff <= dv_ff[NS];
      end
      if (ce) begin
         otan_ff <= dneg_ff[NS] ? (~mag_in + QW'(1)) : mag_in;
         oerr_ff <= err_in;
      end
   end

endmodule
